// ===== design/quadratic_probe_hash_table_top_defines.svh =====
// Assertion macros shared by the hash table modules.
`ifndef QUADRATIC_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define QPHT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qpht: same-cycle check failed");
// Next-cycle implication check.
`define QPHT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qpht: next-cycle check failed");
`else
`define QPHT_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define QPHT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== design/qpht_pkg.sv =====
package qpht_pkg;

   localparam int KEY_W  = 32;
   localparam int OP_W   = 2;
   localparam int SLOT_W = 10;
   localparam int ST_W   = 2;
   localparam int CFG_W  = 11;

   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [ST_W-1:0] ST_PRESENT  = 2'd0;
   localparam logic [ST_W-1:0] ST_ABSENT   = 2'd1;
   localparam logic [ST_W-1:0] ST_INSERTED = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [ST_W-1:0]   status;
   } rsp_type;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_wr;
      logic accept;
      logic probe_init;
      logic rd_en;
      logic advance;
      logic finish;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic slot_empty;
      logic key_match;
      logic probe_last;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== design/qpht_div.sv =====
module qpht_div #(
   parameter int SZ_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [qpht_pkg::KEY_W-1:0]  dividend,
   input  logic [SZ_W-1:0]             divisor,
   output logic                        done,
   output logic [SZ_W-1:0]             rem
);
   import qpht_pkg::*;

   localparam int CNT_W = $clog2(KEY_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [KEY_W-1:0]  shift_ff, shift_in;
   logic [SZ_W-1:0]   rem_ff, rem_in;
   logic [SZ_W:0]     trial;
   logic [SZ_W:0]     diff;

   // Restoring remainder, one dividend bit per cycle, most significant first.
   always_comb begin
      trial    = {rem_ff, shift_ff[KEY_W-1]};
      diff     = trial - {1'b0, divisor};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[SZ_W-1:0];
         end else begin
            rem_in = trial[SZ_W-1:0];
         end
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== design/qpht_dp.sv =====
`include "quadratic_probe_hash_table_top_defines.svh"

module qpht_dp #(
   parameter int MAX_SLOTS = 1024,
   parameter int IDX_W     = 10,
   parameter int SZ_W      = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  qpht_pkg::cmd_type           cmd,
   output qpht_pkg::stat_type          stat,
   input  qpht_pkg::req_type           req_data,
   input  logic [qpht_pkg::CFG_W-1:0]  table_size,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output qpht_pkg::rsp_type           rsp_data
);
   import qpht_pkg::*;

   localparam int CMP_W = (CFG_W > SZ_W) ? CFG_W : SZ_W;
   localparam int AW    = SZ_W + 1;

   logic [CMP_W-1:0]        ts_wide;
   logic [CMP_W-1:0]        size_wide;
   logic [SZ_W-1:0]         size;

   logic [OP_W-1:0]         op_ff, op_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [IDX_W-1:0]        loc_ff, loc_in;
   logic [IDX_W-1:0]        d_ff, d_in;
   logic [SZ_W-1:0]         i_ff, i_in;
   logic [ST_W-1:0]         status_ff, status_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   entry_type               rdata_ff;

   entry_type               slot_mem [MAX_SLOTS];

   logic                    div_done;
   logic [SZ_W-1:0]         div_rem;
   logic [AW-1:0]           loc_sum, loc_red;
   logic [AW-1:0]           d_sum, d_red;
   logic [SZ_W:0]           i_inc;
   logic                    slot_empty, key_match;
   logic                    ins_wr, del_wr, wr_en;
   logic [IDX_W-1:0]        waddr;
   entry_type               wdata;
   logic [IDX_W+SLOT_W-1:0] loc_wide;

   // A size of zero counts as one slot; sizes above the storage count as full storage.
   always_comb begin
      ts_wide = CMP_W'(table_size);
      if (ts_wide == '0) begin
         size_wide = CMP_W'(1);
      end else if (ts_wide > CMP_W'(MAX_SLOTS)) begin
         size_wide = CMP_W'(MAX_SLOTS);
      end else begin
         size_wide = ts_wide;
      end
      size = size_wide[SZ_W-1:0];
   end

   qpht_div #(.SZ_W(SZ_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept),
      .dividend (req_data.key),
      .divisor  (size),
      .done     (div_done),
      .rem      (div_rem)
   );

   // Probe i steps by 2i+1; both the position and the step stay reduced below the size.
   always_comb begin
      loc_sum = AW'(loc_ff) + AW'(d_ff);
      loc_red = (loc_sum >= AW'(size)) ? loc_sum - AW'(size) : loc_sum;
      d_sum   = AW'(d_ff) + AW'(2);
      d_red   = (d_sum >= AW'(size)) ? d_sum - AW'(size) : d_sum;
      i_inc   = {1'b0, i_ff} + 1'b1;
   end

   assign slot_empty = !rdata_ff.used;
   assign key_match  = rdata_ff.used && (rdata_ff.key == key_ff);

   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      loc_in    = loc_ff;
      d_in      = d_ff;
      i_in      = i_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         op_in  = req_data.opcode;
         key_in = req_data.key;
      end
      if (cmd.probe_init) begin
         loc_in = div_rem[IDX_W-1:0];
         d_in   = (size == SZ_W'(1)) ? '0 : IDX_W'(1);
         i_in   = '0;
      end
      if (cmd.advance) begin
         loc_in = loc_red[IDX_W-1:0];
         d_in   = d_red[IDX_W-1:0];
         i_in   = i_inc[SZ_W-1:0];
      end
      if (cmd.finish) begin
         if (slot_empty) begin
            status_in = (op_ff == OP_INSERT) ? ST_INSERTED : ST_ABSENT;
         end else if (key_match) begin
            status_in = ST_PRESENT;
         end else begin
            status_in = ST_FULL;
         end
      end
   end

   always_comb begin
      ins_wr     = cmd.finish && slot_empty && (op_ff == OP_INSERT);
      del_wr     = cmd.finish && key_match && (op_ff == OP_DELETE);
      wr_en      = cmd.clr_wr || ins_wr || del_wr;
      waddr      = cmd.clr_wr ? clr_ff : loc_ff;
      wdata.used = ins_wr;
      wdata.key  = key_ff;
      clr_in     = cmd.clr_wr ? clr_ff + 1'b1 : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= slot_mem[loc_ff];
      end
   end

   always_comb begin
      loc_wide           = {{SLOT_W{1'b0}}, loc_ff};
      rsp_data_in        = rsp_data_ff;
      rsp_valid_in       = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.slot   = loc_wide[SLOT_W-1:0];
         rsp_data_in.status = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      loc_ff      <= loc_in;
      d_ff        <= d_in;
      i_ff        <= i_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.clr_last   = (clr_ff == IDX_W'(MAX_SLOTS - 1));
      stat.div_done   = div_done;
      stat.slot_empty = slot_empty;
      stat.key_match  = key_match;
      stat.probe_last = (i_inc == {1'b0, size});
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `QPHT_ASSERT_IMPLY(a_read_in_range, clock, reset, cmd.rd_en, loc_ff < size)
   `QPHT_ASSERT_IMPLY(a_probe_bound, clock, reset, cmd.rd_en, i_ff < size)
   `QPHT_ASSERT_NEXT(a_insert_claims, clock, reset, ins_wr, status_ff == ST_INSERTED)

endmodule

// ===== design/qpht_ctrl.sv =====
`include "quadratic_probe_hash_table_top_defines.svh"

module qpht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qpht_pkg::stat_type  stat,
   output qpht_pkg::cmd_type   cmd
);
   import qpht_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DIV   = 6'b000100,
      S_READ  = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.probe_init = 1'b1;
               state_in       = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (stat.slot_empty || stat.key_match || stat.probe_last) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `QPHT_ASSERT_NEXT(a_accept_divides, clock, reset, cmd.accept, state_ff == S_DIV)
   `QPHT_ASSERT_IMPLY(a_load_free, clock, reset, cmd.out_load, !stat.rsp_busy)
   `QPHT_ASSERT_NEXT(a_read_then_check, clock, reset, cmd.rd_en, state_ff == S_CHECK)

endmodule

// ===== design/quadratic_probe_hash_table_top.sv =====
// Open-addressed hash table of 32-bit keys with quadratic probing. Each item on the
// request channel is a find, insert or delete of one key; each gives exactly one
// item on the response channel with the slot where probing stopped and a status
// (present, absent, newly inserted or table full). The home slot is the key modulo
// the table size held in the one configuration register (reset 1024, zero counts
// as one, values above MAX_SLOTS count as MAX_SLOTS), and probe i visits
// home + i*i, wrapping at that size. Items are handled one at a time. The modulo
// runs in a bit-serial remainder unit, and each probe reads the slot memory
// through its one registered read port before the slot is checked. The number
// of slots probed per item is at least one and at most the table size. A result
// waiting on the response channel does not keep a new request from being taken.
// After reset the block clears the used marks with one pass through the slot
// memory, one entry per cycle; no request is taken during that pass, but
// configuration writes are. The size register should only be written while no
// request is in progress.
module quadratic_probe_hash_table_top #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  qpht_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output qpht_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [qpht_pkg::CFG_W-1:0]  csr_data
);
   import qpht_pkg::*;

   // Slot index width and the width needed to hold the slot count itself.
   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int SZ_W  = $clog2(MAX_SLOTS + 1);

   logic [CFG_W-1:0] table_size_ff, table_size_in;
   cmd_type          cmd;
   stat_type         stat;

   // The size register is always ready to take a write.
   assign csr_ready     = 1'b1;
   assign table_size_in = (csr_valid && csr_ready) ? csr_data : table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // The controller sequences the clearing pass, the remainder, the probe walk and
   // the hand-off of each result item to the output register.
   qpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the slot memory, the remainder unit, the probe position and
   // step, and the response register.
   qpht_dp #(
      .MAX_SLOTS (MAX_SLOTS),
      .IDX_W     (IDX_W),
      .SZ_W      (SZ_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .table_size (table_size_ff),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
